// ===== rtl/ufdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ufdc_pkg
// Shared types, codes and the CRC-32 byte table for the frame deframer.
// ----------------------------------------------------------------------------
package ufdc_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [7:0]  TYPE_RST  = 8'hA0;
  localparam logic [3:0]  MAX_ERR_RST = 4'd3;

  localparam int unsigned OUT_DATA_W = 64;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ABORT   = 2'd2
  } kind_t;

  // Work codes handed from the parser to the back end
  typedef enum logic [2:0] {
    OP_CRC_FIRST = 3'd0,  // type byte: restart CRC
    OP_CRC_UPD   = 3'd1,  // header byte: CRC only
    OP_PAYLOAD   = 3'd2,  // payload byte: CRC and emit
    OP_RX_CRC    = 3'd3,  // received CRC byte, not the last
    OP_FINAL     = 3'd4,  // last CRC byte: check and emit
    OP_ABORT     = 3'd5   // timeout: drop frame and emit
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  rx_data;
    logic [15:0] index;
    logic [7:0]  ftype;
    logic [7:0]  fseq;
    logic [15:0] flen;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [31:0] crc_tab_t [256];

  function automatic crc_tab_t crc_table_gen();
    crc_tab_t    t;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TABLE = crc_table_gen();

  // Reflected CRC-32, one byte per call via the table
  function automatic logic [31:0] crc_upd(input logic [31:0] crc, input logic [7:0] b);
    return (crc >> 8) ^ CRC_TABLE[crc[7:0] ^ b];
  endfunction

endpackage

// ===== rtl/ufdc_front.sv =====
// ----------------------------------------------------------------------------
// ufdc_front
// Frame parser: tracks byte position and header, tags each byte with work.
// ----------------------------------------------------------------------------
module ufdc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_abort,
  input  logic [7:0]        in_byte,
  input  ufdc_pkg::q_stat_t q_stat,
  output logic              in_ready,
  output logic              push,
  output ufdc_pkg::entry_t  push_entry
);

  logic [16:0] pos_r, pos_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;
  logic [16:0] p;
  logic [16:0] idx_full;
  logic        take;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;
  assign push     = take;
  assign p        = pos_r + 17'd1;
  assign idx_full = p - 17'd5;

  always_comb begin
    pos_nxt  = pos_r;
    type_nxt = type_r;
    seq_nxt  = seq_r;
    len_nxt  = len_r;
    push_entry.op      = ufdc_pkg::OP_ABORT;
    push_entry.rx_data = in_byte;
    push_entry.index   = idx_full[15:0];
    push_entry.ftype   = type_r;
    push_entry.fseq    = seq_r;
    push_entry.flen    = len_r;
    if (take) begin
      if (in_abort) begin
        pos_nxt = '0;
        push_entry.op = ufdc_pkg::OP_ABORT;
      end else begin
        pos_nxt = p;
        if (p == 17'd1) begin
          type_nxt = in_byte;
          push_entry.op = ufdc_pkg::OP_CRC_FIRST;
        end else if (p == 17'd2) begin
          seq_nxt = in_byte;
          push_entry.op = ufdc_pkg::OP_CRC_UPD;
        end else if (p <= 17'd4) begin
          len_nxt = {len_r[7:0], in_byte};
          push_entry.op = ufdc_pkg::OP_CRC_UPD;
        end else if (p <= {1'b0, len_r} + 17'd4) begin
          push_entry.op = ufdc_pkg::OP_PAYLOAD;
        end else if (p < {1'b0, len_r} + 17'd8) begin
          push_entry.op = ufdc_pkg::OP_RX_CRC;
        end else begin
          push_entry.op = ufdc_pkg::OP_FINAL;
          pos_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      type_r <= ufdc_pkg::TYPE_RST;
      seq_r  <= '0;
      len_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      type_r <= type_nxt;
      seq_r  <= seq_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

// ===== rtl/ufdc_queue.sv =====
// ----------------------------------------------------------------------------
// ufdc_queue
// Short register FIFO between the parser and the CRC/result back end.
// ----------------------------------------------------------------------------
module ufdc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ufdc_pkg::entry_t  push_entry,
  input  logic              pop,
  output ufdc_pkg::entry_t  pop_entry,
  output ufdc_pkg::q_stat_t q_stat
);

  ufdc_pkg::entry_t                  mem_r [ufdc_pkg::QDepth];
  logic [ufdc_pkg::QPtrW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [ufdc_pkg::QPtrW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [ufdc_pkg::QCntW-1:0]        cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == ufdc_pkg::QCntW'(ufdc_pkg::QDepth));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_entry    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/ufdc_back.sv =====
// ----------------------------------------------------------------------------
// ufdc_back
// Executes queued work: running CRC, CRC check, failure count, result reg.
// ----------------------------------------------------------------------------
module ufdc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [3:0]                          cfg_wr_data,
  input  ufdc_pkg::q_stat_t                   q_stat,
  input  ufdc_pkg::entry_t                    pop_entry,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [1:0]                          out_tuser,
  output logic [ufdc_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rxcrc_r, rxcrc_nxt;
  logic [3:0]  fail_r, fail_nxt;
  logic [3:0]  max_err_r;
  logic        oval_r, oval_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [ufdc_pkg::OUT_DATA_W-1:0] odata_r, odata_nxt;

  logic        emits;
  logic        good;
  logic        retry;
  logic [31:0] crc_in;

  assign emits = pop_entry.op inside {ufdc_pkg::OP_PAYLOAD, ufdc_pkg::OP_FINAL,
                                      ufdc_pkg::OP_ABORT};
  assign pop   = !q_stat.empty && (!emits || !oval_r || out_tready);

  // first header byte restarts the CRC
  assign crc_in = (pop_entry.op == ufdc_pkg::OP_CRC_FIRST) ? ufdc_pkg::CRC_INIT : crc_r;

  always_comb begin
    crc_nxt   = crc_r;
    rxcrc_nxt = rxcrc_r;
    fail_nxt  = fail_r;
    oval_nxt  = oval_r && !out_tready;
    okind_nxt = okind_r;
    odata_nxt = odata_r;
    good      = 1'b0;
    retry     = 1'b0;
    if (pop) begin
      case (pop_entry.op)
        ufdc_pkg::OP_CRC_FIRST, ufdc_pkg::OP_CRC_UPD: begin
          crc_nxt = ufdc_pkg::crc_upd(crc_in, pop_entry.rx_data);
        end
        ufdc_pkg::OP_PAYLOAD: begin
          crc_nxt   = ufdc_pkg::crc_upd(crc_r, pop_entry.rx_data);
          oval_nxt  = 1'b1;
          okind_nxt = ufdc_pkg::KIND_PAYLOAD;
          odata_nxt = {2'b00, fail_r, 1'b0, 1'b0, 16'd0, 8'd0, 8'd0,
                       pop_entry.index, pop_entry.rx_data};
        end
        ufdc_pkg::OP_RX_CRC: begin
          rxcrc_nxt = {rxcrc_r[23:0], pop_entry.rx_data};
        end
        ufdc_pkg::OP_FINAL: begin
          rxcrc_nxt = {rxcrc_r[23:0], pop_entry.rx_data};
          good      = (~crc_r == rxcrc_nxt);
          if (good) begin
            fail_nxt = '0;
          end else if (fail_r < max_err_r) begin
            fail_nxt = fail_r + 4'd1;
            retry    = 1'b1;
          end
          oval_nxt  = 1'b1;
          okind_nxt = ufdc_pkg::KIND_DONE;
          odata_nxt = {2'b00, fail_nxt, retry, good, pop_entry.flen, pop_entry.fseq,
                       pop_entry.ftype, 16'd0, 8'd0};
        end
        ufdc_pkg::OP_ABORT: begin
          crc_nxt   = ufdc_pkg::CRC_INIT;
          oval_nxt  = 1'b1;
          okind_nxt = ufdc_pkg::KIND_ABORT;
          odata_nxt = {2'b00, fail_r, 58'd0};
        end
        default: begin
          crc_nxt = crc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= ufdc_pkg::CRC_INIT;
      rxcrc_r   <= '0;
      fail_r    <= '0;
      max_err_r <= ufdc_pkg::MAX_ERR_RST;
      oval_r    <= 1'b0;
    end else begin
      crc_r   <= crc_nxt;
      rxcrc_r <= rxcrc_nxt;
      fail_r  <= fail_nxt;
      oval_r  <= oval_nxt;
      if (cfg_wr_en) begin
        max_err_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = odata_r;

endmodule

// ===== rtl/uart_frame_deframer_crc32.sv =====
// ----------------------------------------------------------------------------
// uart_frame_deframer_crc32
// Length-prefixed frame parser with CRC-32 check and consecutive-error count.
// ----------------------------------------------------------------------------
// Pipeline: two register stages (parser -> queue, queue -> table CRC update
//   and result register); a stalled result can hold entries in the queue.
// Throughput: one byte per cycle while the queue is not full; the back end
//   retires one queue entry a cycle unless a result is stalled on out_tready.
// Reset (rst_n low, synchronous): position, seq, length, error count and
//   queue cleared, type 8'hA0, CRC all ones, max_errors 3; no result pending.
module uart_frame_deframer_crc32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] action (1 = timeout abort)
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_type,
  // [39:32] frame_seq, [55:40] frame_length, [56] crc_good,
  // [57] retry_request, [61:58] error_count, [63:62] zero
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data // [3:0] max_errors
);

  ufdc_pkg::q_stat_t q_stat;
  ufdc_pkg::entry_t  push_entry;
  ufdc_pkg::entry_t  pop_entry;
  logic              push;
  logic              pop;

  ufdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_abort   (in_tuser),
    .in_byte    (in_tdata),
    .q_stat     (q_stat),
    .in_ready   (in_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  ufdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  ufdc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .pop_entry   (pop_entry),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata)
  );

endmodule

// ===== rtl/ufdc_checker.sv =====
// ----------------------------------------------------------------------------
// ufdc_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
module ufdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ufdc_pkg::KIND_PAYLOAD) ||
                   (out_tuser == ufdc_pkg::KIND_DONE) ||
                   (out_tuser == ufdc_pkg::KIND_ABORT))
    else $error("illegal result kind");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ufdc_pkg::KIND_PAYLOAD) |-> (out_tdata[57:24] == '0))
    else $error("frame fields set on a payload result");

  a_retry_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[57] |-> !out_tdata[56] && (out_tuser == ufdc_pkg::KIND_DONE)
                                    && (out_tdata[61:58] != 4'd0))
    else $error("retry on good CRC or non-complete result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind uart_frame_deframer_crc32 ufdc_checker u_ufdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
